>>> hdl/sstk_pkg.sv
`default_nettype none
package sstk_pkg;

  // capacities
  localparam int MAX_POSITIONS = 4096;
  localparam int MAX_CHUNKS    = 64;

  // derived widths
  localparam int POS_W = $clog2(MAX_POSITIONS);
  localparam int LEN_W = POS_W + 1;
  localparam int CH_W  = $clog2(MAX_CHUNKS);
  localparam int CNT_W = CH_W + 1;

  // datapath widths
  localparam int SUM_W = 48;
  localparam int WIN_W = 56;
  localparam int DIV_W = 60;
  localparam int DVS_W = 13;
  localparam int CFG_W = 17;
  localparam int IDX_W = 2;

  // register indexes
  localparam logic [IDX_W-1:0] CFG_CHUNK_LEN     = 2'd0;
  localparam logic [IDX_W-1:0] CFG_POOL_WIDTH    = 2'd1;
  localparam logic [IDX_W-1:0] CFG_KEEP_FRACTION = 2'd2;

  // register reset values
  localparam logic [12:0] CHUNK_LEN_RST     = 13'd64;
  localparam logic [7:0]  POOL_WIDTH_RST    = 8'd13;
  localparam logic [16:0] KEEP_FRACTION_RST = 17'd32768;
  localparam logic [16:0] KEEP_ALL          = 17'd65536;

  // item functions
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

  // status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  typedef struct packed {
    logic               func;
    logic [11:0]        position;
    logic signed [31:0] sample;
    logic [12:0]        seq_length;
  } in_item_t;

  typedef struct packed {
    logic [11:0] span_begin;
    logic [12:0] span_finish;
    logic        last_span;
    logic        status;
  } out_item_t;

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] dividend;
    logic [DVS_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_COUNT,
    ST_WIN_RD,
    ST_WIN_ACC,
    ST_F_START,
    ST_F_WAIT,
    ST_C_START,
    ST_C_WAIT,
    ST_UPD_A,
    ST_UPD_A2,
    ST_UPD_S,
    ST_UPD_S2,
    ST_CLEAR,
    ST_SEL_INIT,
    ST_SEL_RD,
    ST_SEL_GET,
    ST_SC_RD,
    ST_SC_CMP,
    ST_EMIT,
    ST_ERR_OUT
  } state_t;

endpackage
`default_nettype wire

>>> hdl/sstk_ram.sv
`default_nettype none
module sstk_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/sstk_div.sv
`default_nettype none
module sstk_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sstk_pkg::div_req_t req,
  output sstk_pkg::div_rsp_t      rsp
);

  localparam int CNT_BITS = $clog2(sstk_pkg::DIV_W);

  logic                              busy;
  logic                              fix;
  logic                              done;
  logic [CNT_BITS-1:0]               cnt;
  logic [sstk_pkg::DIV_W-1:0]        quo;
  logic [sstk_pkg::DVS_W-1:0]        rem;
  logic [sstk_pkg::DVS_W-1:0]        dvs;
  logic                              neg;
  logic signed [sstk_pkg::DIV_W-1:0] result;
  logic [sstk_pkg::DVS_W:0]          shifted;
  logic                              fits;
  logic                              last_step;

  // one quotient bit per cycle
  assign shifted   = {rem, quo[sstk_pkg::DIV_W-1]};
  assign fits      = shifted >= {1'b0, dvs};
  assign last_step = busy && (cnt == CNT_BITS'(sstk_pkg::DIV_W - 1));

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fix;
      fix  <= last_step;
      if (req.start) begin
        busy <= 1'b1;
      end else if (last_step) begin
        busy <= 1'b0;
      end
    end
  end

  // magnitude divide, then floor correction for negative dividends
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend[sstk_pkg::DIV_W-1] ? sstk_pkg::DIV_W'(-req.dividend)
                                              : sstk_pkg::DIV_W'(req.dividend);
      rem <= '0;
      dvs <= req.divisor;
      neg <= req.dividend[sstk_pkg::DIV_W-1];
      cnt <= '0;
    end else if (busy) begin
      quo <= {quo[sstk_pkg::DIV_W-2:0], fits};
      rem <= fits ? sstk_pkg::DVS_W'(shifted - {1'b0, dvs}) : shifted[sstk_pkg::DVS_W-1:0];
      cnt <= cnt + CNT_BITS'(1);
    end
    if (fix) begin
      result <= neg ? $signed(~quo + sstk_pkg::DIV_W'(rem == '0)) : $signed(quo);
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = result;

endmodule
`default_nettype wire

>>> hdl/score_smooth_topk_span_select_unit.sv
`default_nettype none
// Chunk-mean top-k span selector. Load transactions (func 0) add a signed
// Q16.16 sample into a per-position sum held in a 4096-entry memory (read,
// then saturating write back). A run transaction (func 1) counts chunks; more
// than 64 ends it with an overflow status. Otherwise it slides a box window
// across the sequence: window prefill reads the positions up to half the
// pool width, then every position costs one pass of the shared bit-serial
// divider plus a window update, and every chunk costs one more divider pass
// for its mean. A clearing pass then zeroes all 4096 sums, the top-k
// selection ranks chunk means out of a 64-entry memory, and the spans are
// walked out one chunk per cycle, stalling only on a full output register.
// After reset the same clearing pass runs before the first transaction is
// taken; configuration writes are accepted at any time.
module score_smooth_topk_span_select_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire sstk_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output sstk_pkg::out_item_t                   out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sstk_pkg::IDX_W-1:0]       cfg_index,
  input  wire logic [sstk_pkg::CFG_W-1:0]       cfg_data
);

  localparam int POS_W = sstk_pkg::POS_W;
  localparam int LEN_W = sstk_pkg::LEN_W;
  localparam int CH_W  = sstk_pkg::CH_W;
  localparam int CNT_W = sstk_pkg::CNT_W;
  localparam int SUM_W = sstk_pkg::SUM_W;
  localparam int WIN_W = sstk_pkg::WIN_W;
  localparam int DIV_W = sstk_pkg::DIV_W;

  // configuration
  logic [12:0] chunk_len;
  logic [7:0]  pool_width;
  logic [16:0] keep_fraction;

  // control
  sstk_pkg::state_t state, state_next;
  logic                          init;
  logic                          err;
  logic [POS_W-1:0]              clr_idx;
  logic [sstk_pkg::MAX_CHUNKS-1:0] kept;

  // run datapath
  logic [LEN_W-1:0]        seq_len;
  logic signed [LEN_W:0]   rem;
  logic [CNT_W-1:0]        nch;
  logic [LEN_W-1:0]        j;
  logic [LEN_W-1:0]        idx;
  logic signed [WIN_W-1:0] win;
  logic signed [DIV_W-1:0] acc;
  logic [LEN_W-1:0]        kin;
  logic [CNT_W-1:0]        c;
  logic [CNT_W-1:0]        d;
  logic [CNT_W-1:0]        rank;
  logic [CNT_W-1:0]        nkeep;
  logic signed [SUM_W-1:0] mc;
  logic [LEN_W:0]          st;
  logic [11:0]             sb;
  logic [12:0]             sf;
  logic                    open_span;
  logic [POS_W-1:0]        ld_pos;
  logic signed [31:0]      ld_sample;

  // memories and divider
  logic                ps_we;
  logic [POS_W-1:0]    ps_waddr, ps_raddr;
  logic [SUM_W-1:0]    ps_wdata, ps_rdata;
  logic                cm_we;
  logic [CH_W-1:0]     cm_raddr;
  logic [SUM_W-1:0]    cm_rdata;
  sstk_pkg::div_req_t  div_req;
  sstk_pkg::div_rsp_t  div_rsp;

  // derived values
  logic [12:0]             cl_eff;
  logic [6:0]              half;
  logic [16:0]             keep_eff;
  logic [LEN_W-1:0]        s_in;
  logic [LEN_W-1:0]        s_last;
  logic [LEN_W:0]          jh;
  logic [LEN_W:0]          add_idx;
  logic                    add_ok;
  logic                    sub_ok;
  logic [LEN_W-1:0]        hi, lo, wlen, init_hi;
  logic                    chunk_end;
  logic                    run_last;
  logic                    rem_pos;
  logic signed [SUM_W:0]   sat_sum;
  logic [SUM_W-1:0]        sat_val;
  logic signed [SUM_W-1:0] mean_rd;
  logic                    hit;
  logic [CNT_W-1:0]        rank_n;
  logic [23:0]             keep_prod;
  logic [LEN_W:0]          en_sum;
  logic [LEN_W-1:0]        en;
  logic                    merge;
  logic                    slot_free;
  logic                    out_load;
  sstk_pkg::out_item_t     out_next;
  logic                    stall;
  logic [SUM_W-1:0]        q_low;

  sstk_ram #(.DEPTH(sstk_pkg::MAX_POSITIONS), .WIDTH(SUM_W)) u_sums (
    .clk   (clk),
    .we    (ps_we),
    .waddr (ps_waddr),
    .wdata (ps_wdata),
    .raddr (ps_raddr),
    .rdata (ps_rdata)
  );

  sstk_ram #(.DEPTH(sstk_pkg::MAX_CHUNKS), .WIDTH(SUM_W)) u_means (
    .clk   (clk),
    .we    (cm_we),
    .waddr (c[CH_W-1:0]),
    .wdata (q_low),
    .raddr (cm_raddr),
    .rdata (cm_rdata)
  );

  sstk_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_len     <= sstk_pkg::CHUNK_LEN_RST;
      pool_width    <= sstk_pkg::POOL_WIDTH_RST;
      keep_fraction <= sstk_pkg::KEEP_FRACTION_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sstk_pkg::CFG_CHUNK_LEN:     chunk_len     <= cfg_data[12:0];
        sstk_pkg::CFG_POOL_WIDTH:    pool_width    <= cfg_data[7:0];
        sstk_pkg::CFG_KEEP_FRACTION: keep_fraction <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective settings
  assign cl_eff   = (chunk_len == '0) ? 13'd1 : chunk_len;
  assign half     = pool_width[7:1];
  assign keep_eff = (keep_fraction > sstk_pkg::KEEP_ALL) ? sstk_pkg::KEEP_ALL : keep_fraction;
  assign s_in     = (in_data.seq_length == '0) ? LEN_W'(1)
                  : (in_data.seq_length > LEN_W'(sstk_pkg::MAX_POSITIONS))
                    ? LEN_W'(sstk_pkg::MAX_POSITIONS) : in_data.seq_length;

  // window bounds around position j
  assign s_last  = seq_len - LEN_W'(1);
  assign jh      = {1'b0, j} + (LEN_W + 1)'(half);
  assign add_idx = jh + (LEN_W + 1)'(1);
  assign add_ok  = add_idx < {1'b0, seq_len};
  assign sub_ok  = j >= LEN_W'(half);
  assign hi      = (jh < {1'b0, s_last}) ? jh[LEN_W-1:0] : s_last;
  assign lo      = sub_ok ? (j - LEN_W'(half)) : '0;
  assign wlen    = hi - lo + LEN_W'(1);
  assign init_hi = (LEN_W'(half) < s_last) ? LEN_W'(half) : s_last;
  assign run_last  = (j + LEN_W'(1)) == seq_len;
  assign chunk_end = ((kin + LEN_W'(1)) == cl_eff) || run_last;
  assign rem_pos   = !rem[LEN_W] && (rem != '0);
  assign q_low     = div_rsp.quotient[SUM_W-1:0];

  // saturating add for loads
  assign sat_sum = $signed({ps_rdata[SUM_W-1], ps_rdata})
                 + $signed({{(SUM_W - 31){ld_sample[31]}}, ld_sample});
  always_comb begin
    if (sat_sum[SUM_W] != sat_sum[SUM_W-1]) begin
      sat_val = sat_sum[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
    end else begin
      sat_val = sat_sum[SUM_W-1:0];
    end
  end

  // ranking compare, ties to the lower index
  assign mean_rd   = $signed(cm_rdata);
  assign hit       = (mean_rd > mc) || ((mean_rd == mc) && (d < c));
  assign rank_n    = rank + CNT_W'(hit);
  assign keep_prod = 24'(nch) * 24'(keep_eff);

  // span walk
  assign en_sum    = st + (LEN_W + 1)'(cl_eff);
  assign en        = (en_sum < {1'b0, seq_len}) ? en_sum[LEN_W-1:0] : seq_len;
  assign merge     = open_span && ({1'b0, sf} >= st);
  assign slot_free = !out_valid || out_ready;
  assign stall     = kept[c[CH_W-1:0]] && open_span && !merge && !slot_free;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sstk_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state, memory ports, divider request, output load
  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    ps_we            = 1'b0;
    ps_waddr         = clr_idx;
    ps_wdata         = '0;
    ps_raddr         = '0;
    cm_we            = 1'b0;
    cm_raddr         = '0;
    div_req.start    = 1'b0;
    div_req.dividend = {{(DIV_W - WIN_W){win[WIN_W-1]}}, win};
    div_req.divisor  = wlen;
    out_load         = 1'b0;
    out_next         = '0;
    case (state)
      sstk_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ps_raddr = in_data.position;
        if (in_valid) begin
          state_next = (in_data.func == sstk_pkg::FUNC_RUN) ? sstk_pkg::ST_COUNT
                                                             : sstk_pkg::ST_LOAD_WR;
        end
      end
      sstk_pkg::ST_LOAD_WR: begin
        ps_we      = 1'b1;
        ps_waddr   = ld_pos;
        ps_wdata   = sat_val;
        state_next = sstk_pkg::ST_IDLE;
      end
      sstk_pkg::ST_COUNT: begin
        if (rem_pos) begin
          if (nch == CNT_W'(sstk_pkg::MAX_CHUNKS)) begin
            state_next = sstk_pkg::ST_CLEAR;
          end
        end else begin
          state_next = sstk_pkg::ST_WIN_RD;
        end
      end
      sstk_pkg::ST_WIN_RD: begin
        ps_raddr   = idx[POS_W-1:0];
        state_next = sstk_pkg::ST_WIN_ACC;
      end
      sstk_pkg::ST_WIN_ACC: begin
        state_next = (idx == init_hi) ? sstk_pkg::ST_F_START : sstk_pkg::ST_WIN_RD;
      end
      sstk_pkg::ST_F_START: begin
        div_req.start = 1'b1;
        state_next    = sstk_pkg::ST_F_WAIT;
      end
      sstk_pkg::ST_F_WAIT: begin
        if (div_rsp.done) begin
          state_next = chunk_end ? sstk_pkg::ST_C_START : sstk_pkg::ST_UPD_A;
        end
      end
      sstk_pkg::ST_C_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = acc;
        div_req.divisor  = kin;
        state_next       = sstk_pkg::ST_C_WAIT;
      end
      sstk_pkg::ST_C_WAIT: begin
        if (div_rsp.done) begin
          cm_we      = 1'b1;
          state_next = run_last ? sstk_pkg::ST_CLEAR : sstk_pkg::ST_UPD_A;
        end
      end
      sstk_pkg::ST_UPD_A: begin
        ps_raddr   = add_idx[POS_W-1:0];
        state_next = add_ok ? sstk_pkg::ST_UPD_A2 : sstk_pkg::ST_UPD_S;
      end
      sstk_pkg::ST_UPD_A2: begin
        state_next = sstk_pkg::ST_UPD_S;
      end
      sstk_pkg::ST_UPD_S: begin
        ps_raddr   = lo[POS_W-1:0];
        state_next = sub_ok ? sstk_pkg::ST_UPD_S2 : sstk_pkg::ST_F_START;
      end
      sstk_pkg::ST_UPD_S2: begin
        state_next = sstk_pkg::ST_F_START;
      end
      sstk_pkg::ST_CLEAR: begin
        ps_we    = 1'b1;
        ps_waddr = clr_idx;
        if (clr_idx == POS_W'(sstk_pkg::MAX_POSITIONS - 1)) begin
          state_next = init ? sstk_pkg::ST_IDLE
                     : err  ? sstk_pkg::ST_ERR_OUT : sstk_pkg::ST_SEL_INIT;
        end
      end
      sstk_pkg::ST_SEL_INIT: begin
        state_next = sstk_pkg::ST_SEL_RD;
      end
      sstk_pkg::ST_SEL_RD: begin
        cm_raddr   = c[CH_W-1:0];
        state_next = sstk_pkg::ST_SEL_GET;
      end
      sstk_pkg::ST_SEL_GET: begin
        state_next = sstk_pkg::ST_SC_RD;
      end
      sstk_pkg::ST_SC_RD: begin
        cm_raddr   = d[CH_W-1:0];
        state_next = sstk_pkg::ST_SC_CMP;
      end
      sstk_pkg::ST_SC_CMP: begin
        if (d == nch - CNT_W'(1)) begin
          state_next = (c + CNT_W'(1) == nch) ? sstk_pkg::ST_EMIT : sstk_pkg::ST_SEL_RD;
        end else begin
          state_next = sstk_pkg::ST_SC_RD;
        end
      end
      sstk_pkg::ST_EMIT: begin
        if (c == nch) begin
          if (slot_free) begin
            out_load   = 1'b1;
            out_next   = '{span_begin: sb, span_finish: sf, last_span: 1'b1,
                           status: sstk_pkg::STATUS_OK};
            state_next = sstk_pkg::ST_IDLE;
          end
        end else if (kept[c[CH_W-1:0]] && open_span && !merge && slot_free) begin
          out_load = 1'b1;
          out_next = '{span_begin: sb, span_finish: sf, last_span: 1'b0,
                       status: sstk_pkg::STATUS_OK};
        end
      end
      sstk_pkg::ST_ERR_OUT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_next   = '{span_begin: '0, span_finish: '0, last_span: 1'b1,
                         status: sstk_pkg::STATUS_OVERFLOW};
          state_next = sstk_pkg::ST_IDLE;
        end
      end
      default: state_next = sstk_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      init    <= 1'b1;
      err     <= 1'b0;
      clr_idx <= '0;
      kept    <= '0;
    end else begin
      if (state == sstk_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + POS_W'(1);
        if (clr_idx == POS_W'(sstk_pkg::MAX_POSITIONS - 1)) begin
          init <= 1'b0;
        end
      end
      if (state == sstk_pkg::ST_COUNT) begin
        if (rem_pos && nch == CNT_W'(sstk_pkg::MAX_CHUNKS)) begin
          err  <= 1'b1;
          kept <= '0;
        end else if (!rem_pos) begin
          err <= 1'b0;
        end
      end
      if (state == sstk_pkg::ST_SEL_INIT) begin
        kept <= '0;
      end
      if (state == sstk_pkg::ST_SC_CMP && d == nch - CNT_W'(1)) begin
        kept[c[CH_W-1:0]] <= rank_n < nkeep;
      end
    end
  end

  // run datapath
  always_ff @(posedge clk) begin
    case (state)
      sstk_pkg::ST_IDLE: begin
        ld_pos    <= in_data.position;
        ld_sample <= in_data.sample;
        seq_len   <= s_in;
        rem       <= $signed({1'b0, s_in});
        nch       <= '0;
      end
      sstk_pkg::ST_COUNT: begin
        if (rem_pos && nch != CNT_W'(sstk_pkg::MAX_CHUNKS)) begin
          nch <= nch + CNT_W'(1);
          rem <= rem - $signed({1'b0, cl_eff});
        end
        idx <= '0;
        win <= '0;
        j   <= '0;
        acc <= '0;
        kin <= '0;
        c   <= '0;
      end
      sstk_pkg::ST_WIN_ACC: begin
        win <= win + $signed({{(WIN_W - SUM_W){ps_rdata[SUM_W-1]}}, ps_rdata});
        idx <= idx + LEN_W'(1);
      end
      sstk_pkg::ST_F_WAIT: begin
        if (div_rsp.done) begin
          acc <= acc + $signed({{(DIV_W - SUM_W){q_low[SUM_W-1]}}, q_low});
          kin <= kin + LEN_W'(1);
        end
      end
      sstk_pkg::ST_C_WAIT: begin
        if (div_rsp.done) begin
          c   <= c + CNT_W'(1);
          acc <= '0;
          kin <= '0;
        end
      end
      sstk_pkg::ST_UPD_A2: begin
        win <= win + $signed({{(WIN_W - SUM_W){ps_rdata[SUM_W-1]}}, ps_rdata});
      end
      sstk_pkg::ST_UPD_S: begin
        if (!sub_ok) begin
          j <= j + LEN_W'(1);
        end
      end
      sstk_pkg::ST_UPD_S2: begin
        win <= win - $signed({{(WIN_W - SUM_W){ps_rdata[SUM_W-1]}}, ps_rdata});
        j   <= j + LEN_W'(1);
      end
      sstk_pkg::ST_SEL_INIT: begin
        nkeep <= (keep_prod[23:16] == '0) ? CNT_W'(1) : CNT_W'(keep_prod[23:16]);
        c     <= '0;
      end
      sstk_pkg::ST_SEL_GET: begin
        mc   <= mean_rd;
        d    <= '0;
        rank <= '0;
      end
      sstk_pkg::ST_SC_CMP: begin
        rank <= rank_n;
        d    <= d + CNT_W'(1);
        if (d == nch - CNT_W'(1)) begin
          if (c + CNT_W'(1) == nch) begin
            c         <= '0;
            st        <= '0;
            open_span <= 1'b0;
          end else begin
            c <= c + CNT_W'(1);
          end
        end
      end
      sstk_pkg::ST_EMIT: begin
        if (c != nch && !stall) begin
          if (kept[c[CH_W-1:0]]) begin
            if (!merge) begin
              sb <= st[11:0];
            end
            sf        <= en;
            open_span <= 1'b1;
          end
          c  <= c + CNT_W'(1);
          st <= en_sum;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_goes_write: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.func == sstk_pkg::FUNC_LOAD)
      |=> state == sstk_pkg::ST_LOAD_WR)
    else $error("load transaction did not go to write back");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == sstk_pkg::ST_F_WAIT || state == sstk_pkg::ST_C_WAIT))
    else $error("divider finished with nobody waiting");

  a_err_is_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == sstk_pkg::STATUS_OVERFLOW)
      |-> (out_data.last_span && out_data.span_finish == '0))
    else $error("overflow result not a lone final transaction");

  a_emit_chunks: assert property (@(posedge clk) disable iff (rst)
    (state == sstk_pkg::ST_EMIT)
      |-> (nch != '0 && nch <= CNT_W'(sstk_pkg::MAX_CHUNKS) && kept != '0))
    else $error("span walk without a kept chunk");

  a_final_has_span: assert property (@(posedge clk) disable iff (rst)
    (state == sstk_pkg::ST_EMIT && c == nch) |-> open_span)
    else $error("final span missing");
`endif

endmodule
`default_nettype wire
